// ===== hw/rtl/rtps_pkg.sv =====
// Shared types, constants and helper functions for the triple product sum core.
// Used by rtps_ctrl, rtps_dp and rys_triple_product_sum_core.
package rtps_pkg;

  // Store geometry and root limits
  localparam int STORE_DEPTH = 4096;
  localparam int MAX_ROOTS   = 16;
  localparam int ADDR_W      = 12;
  localparam int IDX_W       = ADDR_W + 1;
  localparam int ROOT_W      = 5;

  // Item opcodes
  localparam logic OPC_WRITE   = 1'b0;
  localparam logic OPC_COMPUTE = 1'b1;

  // binary64 constants
  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] INF_BITS  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;

  typedef logic signed [13:0] exp_t;

  localparam exp_t EXP_BIAS  = 14'sd1075;
  localparam exp_t EXP_MIN   = -14'sd1074;
  localparam exp_t EXP_LIMIT = 14'sd2047;
  localparam logic [6:0] NORM_TOP = 7'd125;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_X, ST_RD_Y, ST_RD_Z, ST_CAP_Z, ST_SPEC, ST_MUL, ST_LZA,
    ST_NORM, ST_ALIGN, ST_ADD, ST_LZC, ST_SHIFT, ST_PACK, ST_NEXT, ST_OUT
  } state_t;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_WRITE, OP_RD_X, OP_RD_Y, OP_RD_Z, OP_CAP_Z,
    OP_SPEC, OP_MUL, OP_LZA, OP_NORM, OP_ALIGN, OP_ADD, OP_LZC, OP_SHIFT,
    OP_PACK, OP_STAGE2, OP_ACCUM, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic [ROOT_W-1:0]   root;
    logic [2:0]          mul_step;
    logic                with_c;
  } dp_cmd_t;

  typedef struct packed {
    logic spec_hit;
    logic use_add;
    logic add_cancel;
    logic out_busy;
  } dp_stat_t;

  function automatic logic is_nan(input logic [63:0] b);
    return (b[62:52] == 11'h7FF) && (b[51:0] != '0);
  endfunction

  function automatic logic is_inf(input logic [63:0] b);
    return (b[62:52] == 11'h7FF) && (b[51:0] == '0);
  endfunction

  function automatic logic is_zero(input logic [63:0] b);
    return b[62:0] == '0;
  endfunction

  function automatic logic [52:0] unpack_m(input logic [63:0] b);
    return (b[62:52] == '0) ? {1'b0, b[51:0]} : {1'b1, b[51:0]};
  endfunction

  function automatic exp_t unpack_e(input logic [63:0] b);
    return (b[62:52] == '0) ? EXP_MIN : ($signed({3'b000, b[62:52]}) - EXP_BIAS);
  endfunction

  // Index of the highest set bit
  function automatic logic [6:0] top_bit(input logic [127:0] v);
    logic [6:0] k;
    k = '0;
    for (int i = 0; i < 128; i++) begin
      if (v[i]) k = 7'(i);
    end
    return k;
  endfunction

  // Right shift; bits shifted out are ORed into bit 0
  function automatic logic [127:0] shr_sticky(input logic [127:0] a, input logic [13:0] s);
    logic [127:0] r;
    logic [127:0] mask;
    if (s >= 14'd128) begin
      r = {127'b0, |a};
    end else begin
      mask = ~({128{1'b1}} << s[6:0]);
      r    = a >> s[6:0];
      r[0] = r[0] | (|(a & mask));
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/rtps_ctrl.sv =====
// Sequencer for the triple product sum core: root loop and FMA step order.
// Depends on rtps_pkg; drives rtps_dp through dp_cmd_t, reads dp_stat_t.
module rtps_ctrl
  import rtps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                opcode,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data,
  output dp_cmd_t             cmd,
  input  dp_stat_t            stat
);

  state_t            state, state_next;
  logic [ROOT_W-1:0] root, root_next;
  logic [ROOT_W-1:0] roots, roots_next;
  logic              phase, phase_next;
  logic [2:0]        mul_step, mul_step_next;
  logic [4:0]        root_count;

  assign cfg_ready = 1'b1;

  // Root count register
  always_ff @(posedge clk) begin
    if (rst) begin
      root_count <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      root_count <= cfg_data;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      root     <= '0;
      roots    <= ROOT_W'(1);
      phase    <= 1'b0;
      mul_step <= '0;
    end else begin
      state    <= state_next;
      root     <= root_next;
      roots    <= roots_next;
      phase    <= phase_next;
      mul_step <= mul_step_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    root_next     = root;
    roots_next    = roots;
    phase_next    = phase;
    mul_step_next = mul_step;
    in_stall      = 1'b1;
    cmd.op        = OP_NONE;
    cmd.root      = root;
    cmd.mul_step  = mul_step;
    cmd.with_c    = phase && (root != '0);
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (opcode == OPC_WRITE) begin
            cmd.op = OP_WRITE;
          end else begin
            cmd.op     = OP_LOAD;
            root_next  = '0;
            phase_next = 1'b0;
            if (root_count == '0) roots_next = ROOT_W'(1);
            else if (root_count > 5'(MAX_ROOTS)) roots_next = ROOT_W'(MAX_ROOTS);
            else roots_next = root_count;
            state_next = ST_RD_X;
          end
        end
      end
      ST_RD_X:  begin cmd.op = OP_RD_X;  state_next = ST_RD_Y;  end
      ST_RD_Y:  begin cmd.op = OP_RD_Y;  state_next = ST_RD_Z;  end
      ST_RD_Z:  begin cmd.op = OP_RD_Z;  state_next = ST_CAP_Z; end
      ST_CAP_Z: begin cmd.op = OP_CAP_Z; state_next = ST_SPEC;  end
      ST_SPEC: begin
        cmd.op        = OP_SPEC;
        mul_step_next = '0;
        state_next    = stat.spec_hit ? ST_NEXT : ST_MUL;
      end
      ST_MUL: begin
        cmd.op        = OP_MUL;
        mul_step_next = mul_step + 3'd1;
        if (mul_step == 3'd4) state_next = stat.use_add ? ST_LZA : ST_LZC;
      end
      ST_LZA:   begin cmd.op = OP_LZA;   state_next = ST_NORM;  end
      ST_NORM:  begin cmd.op = OP_NORM;  state_next = ST_ALIGN; end
      ST_ALIGN: begin cmd.op = OP_ALIGN; state_next = ST_ADD;   end
      ST_ADD: begin
        cmd.op     = OP_ADD;
        state_next = stat.add_cancel ? ST_NEXT : ST_LZC;
      end
      ST_LZC:   begin cmd.op = OP_LZC;   state_next = ST_SHIFT; end
      ST_SHIFT: begin cmd.op = OP_SHIFT; state_next = ST_PACK;  end
      ST_PACK:  begin cmd.op = OP_PACK;  state_next = ST_NEXT;  end
      ST_NEXT: begin
        if (!phase) begin
          cmd.op     = OP_STAGE2;
          phase_next = 1'b1;
          state_next = ST_SPEC;
        end else begin
          cmd.op     = OP_ACCUM;
          phase_next = 1'b0;
          if (root + ROOT_W'(1) == roots) begin
            state_next = ST_OUT;
          end else begin
            root_next  = root + ROOT_W'(1);
            state_next = ST_RD_X;
          end
        end
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.op     = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/rtps_dp.sv =====
// Datapath: factor store, split mantissa multiplier, align/add and rounding.
// Depends on rtps_pkg; sequenced by rtps_ctrl through dp_cmd_t.
module rtps_dp
  import rtps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [ADDR_W-1:0]   write_address,
  input  logic [63:0]         write_value,
  input  logic [ADDR_W-1:0]   x_base,
  input  logic [ADDR_W-1:0]   y_base,
  input  logic [ADDR_W-1:0]   z_base,
  input  logic                batch_end,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [63:0]         sum_value,
  output logic                range_error,
  output logic                batch_end_out
);

  logic [63:0] mem [STORE_DEPTH];

  // Request fields and read path
  logic [ADDR_W-1:0] bx, by, bz;
  logic              be, err;
  logic [63:0]       rdata;
  logic              rd_oob_q;
  logic [63:0]       rval;
  logic [IDX_W-1:0]  idx;
  logic              oob;
  logic [ADDR_W-1:0] base_sel;

  // Arithmetic registers
  logic [63:0]  opa, opb, zq, acc, res;
  logic         sp, sc, with_c_q;
  logic [52:0]  ma, mb;
  logic [53:0]  pp;
  logic [127:0] m, wc;
  exp_t         e, ec, sh;
  logic [6:0]   kp, kc;
  logic [63:0]  w;

  // Specials
  logic        sgn_p, sgn_c;
  logic        spec_hit;
  logic [63:0] spec_val;

  // Shift and pack helpers
  exp_t         sh_a, sh_lim, sh_n, t_s, diff, sh2, biased;
  logic [13:0]  t_u, diff_u;
  logic [127:0] v;
  logic [53:0]  q, q2;
  logic [1:0]   low2;
  logic         inc;
  logic [63:0]  packed_bits;
  logic [26:0]  a0, a1, b0, b1;

  // Store index for the current root
  always_comb begin
    case (cmd.op)
      OP_RD_Y: base_sel = by;
      OP_RD_Z: base_sel = bz;
      default: base_sel = bx;
    endcase
    idx  = {1'b0, base_sel} + IDX_W'(cmd.root);
    oob  = {1'b0, idx} >= (IDX_W + 1)'(STORE_DEPTH);
    rval = rd_oob_q ? 64'd0 : rdata;
  end

  // Factor store
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) mem[write_address] <= write_value;
    if (cmd.op == OP_RD_X || cmd.op == OP_RD_Y || cmd.op == OP_RD_Z) begin
      rdata <= mem[idx[ADDR_W-1:0]];
    end
  end

  // Special operand cases
  always_comb begin
    sgn_p    = opa[63] ^ opb[63];
    sgn_c    = acc[63];
    spec_hit = 1'b1;
    spec_val = 64'd0;
    if (is_nan(opa) || is_nan(opb) || (cmd.with_c && is_nan(acc))) begin
      spec_val = QNAN_BITS;
    end else if (is_inf(opa) || is_inf(opb)) begin
      if (is_zero(opa) || is_zero(opb)) spec_val = QNAN_BITS;
      else if (cmd.with_c && is_inf(acc) && (sgn_c != sgn_p)) spec_val = QNAN_BITS;
      else spec_val = INF_BITS | (sgn_p ? SIGN_BIT : 64'd0);
    end else if (cmd.with_c && is_inf(acc)) begin
      spec_val = acc;
    end else if (is_zero(opa) || is_zero(opb)) begin
      if (!cmd.with_c) spec_val = sgn_p ? SIGN_BIT : 64'd0;
      else if (is_zero(acc)) spec_val = (sgn_p && sgn_c) ? SIGN_BIT : 64'd0;
      else spec_val = acc;
    end else begin
      spec_hit = 1'b0;
    end
  end

  // Rounding shift and packing
  always_comb begin
    sh_a   = $signed({7'b0, kp}) - 14'sd52;
    sh_lim = EXP_MIN - e;
    sh_n   = (sh_lim > sh_a) ? sh_lim : sh_a;
    t_s    = sh_n - 14'sd2;
    t_u    = t_s;
    if (t_s >= 0) v = shr_sticky(m, t_u);
    else          v = m << 6'(-t_s);
    diff   = (e >= ec) ? (e - ec) : (ec - e);
    diff_u = diff;

    q    = {2'b00, w[53:2]} | {w[55:54], 52'd0};
    low2 = w[1:0];
    inc  = (low2 > 2'd2) || ((low2 == 2'd2) && q[0]);
    q2   = q + 54'(inc);
    sh2  = sh;
    if (q2 == 54'(1) << 53) begin
      q2  = q2 >> 1;
      sh2 = sh + 14'sd1;
    end
    biased = e + sh2 + EXP_BIAS;
    if (q2[52]) begin
      if (biased >= EXP_LIMIT) packed_bits = INF_BITS;
      else packed_bits = {1'b0, biased[10:0], q2[51:0]};
    end else begin
      packed_bits = {12'b0, q2[51:0]};
    end
    packed_bits = packed_bits | (sp ? SIGN_BIT : 64'd0);

    a0 = ma[26:0];
    a1 = {1'b0, ma[52:27]};
    b0 = mb[26:0];
    b1 = {1'b0, mb[52:27]};
  end

  assign stat.spec_hit   = spec_hit;
  assign stat.use_add    = with_c_q;
  assign stat.add_cancel = (sp != sc) && (m == wc);
  assign stat.out_busy   = out_valid && out_stall;

  // Datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        bx  <= x_base;
        by  <= y_base;
        bz  <= z_base;
        be  <= batch_end;
        err <= 1'b0;
      end
      OP_RD_X: begin
        rd_oob_q <= oob;
        err      <= err | oob;
      end
      OP_RD_Y: begin
        rd_oob_q <= oob;
        err      <= err | oob;
        opa      <= rval;
      end
      OP_RD_Z: begin
        rd_oob_q <= oob;
        err      <= err | oob;
        opb      <= rval;
      end
      OP_CAP_Z: zq <= rval;
      OP_SPEC: begin
        if (spec_hit) res <= spec_val;
        sp       <= sgn_p;
        sc       <= sgn_c;
        ma       <= unpack_m(opa);
        mb       <= unpack_m(opb);
        e        <= unpack_e(opa) + unpack_e(opb);
        m        <= '0;
        wc       <= {75'b0, unpack_m(acc)};
        ec       <= unpack_e(acc);
        with_c_q <= cmd.with_c && !is_zero(acc);
      end
      OP_MUL: begin
        case (cmd.mul_step)
          3'd0: pp <= a0 * b0;
          3'd1: begin pp <= a0 * b1; m <= m + 128'(pp); end
          3'd2: begin pp <= a1 * b0; m <= m + (128'(pp) << 27); end
          3'd3: begin pp <= a1 * b1; m <= m + (128'(pp) << 27); end
          3'd4: m <= m + (128'(pp) << 54);
          default: ;
        endcase
      end
      OP_LZA: begin
        kp <= NORM_TOP - top_bit(m);
        kc <= NORM_TOP - top_bit(wc);
      end
      OP_NORM: begin
        m  <= m << kp;
        e  <= e - $signed({7'b0, kp});
        wc <= wc << kc;
        ec <= ec - $signed({7'b0, kc});
      end
      OP_ALIGN: begin
        if (e >= ec) begin
          wc <= shr_sticky(wc, diff_u);
        end else begin
          m  <= wc;
          wc <= shr_sticky(m, diff_u);
          sp <= sc;
          sc <= sp;
          e  <= ec;
        end
      end
      OP_ADD: begin
        if (sp == sc) begin
          m <= m + wc;
        end else if (m > wc) begin
          m <= m - wc;
        end else if (m < wc) begin
          m  <= wc - m;
          sp <= sc;
        end else begin
          res <= 64'd0;
        end
      end
      OP_LZC:   kp <= top_bit(m);
      OP_SHIFT: begin
        w  <= v[63:0];
        sh <= sh_n;
      end
      OP_PACK:  res <= packed_bits;
      OP_STAGE2: begin
        opa <= res;
        opb <= zq;
      end
      OP_ACCUM: acc <= res;
      OP_OUT: begin
        sum_value     <= acc;
        range_error   <= err;
        batch_end_out <= be;
      end
      default: ;
    endcase
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/rys_triple_product_sum_core.sv =====
// Triple product sum core: a write request updates the 4096-entry store; a compute request
// over R roots has its result computed by one shared FMA unit (split multiply, align/add,
// rounding), with special operands skipping the multiply and rounding steps; one request
// at a time, the next taken once the controller is back in idle.
// Reset (rst, synchronous) clears control and sets root_count to 1; store contents
// are undefined until written.
module rys_triple_product_sum_core
  import rtps_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         opcode,
  input  logic [11:0]  write_address,
  input  logic [63:0]  write_value,
  input  logic [11:0]  x_base,
  input  logic [11:0]  y_base,
  input  logic [11:0]  z_base,
  input  logic         batch_end,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [63:0]  sum_value,
  output logic         range_error,
  output logic         batch_end_out,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [4:0]   cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rtps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  rtps_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .write_address (write_address),
    .write_value   (write_value),
    .x_base        (x_base),
    .y_base        (y_base),
    .z_base        (z_base),
    .batch_end     (batch_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sum_value     (sum_value),
    .range_error   (range_error),
    .batch_end_out (batch_end_out)
  );

  // A result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  // A loaded result shows up as valid
  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT |=> out_valid)
    else $error("loaded result not presented");

  // A compute request holds off the input side
  a_busy_after_compute: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == OPC_COMPUTE |=> in_stall)
    else $error("input accepted while computing");

endmodule
